FILE: src/sbo_pkg.sv
package sbo_pkg;

  localparam int DEF_MAX_WIDTH  = 2048;
  localparam int DEF_MAX_HEIGHT = 4096;

  localparam int PIX_W      = 8;
  localparam int OUT_COL_W  = 11;
  localparam int OUT_ROW_W  = 12;
  localparam int FW_W       = 12;
  localparam int FH_W       = 13;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 13;

  localparam int RESET_WIDTH  = 640;
  localparam int RESET_HEIGHT = 480;

  // output queue depth; each pixel in flight needs up to two slots
  localparam int QUEUE_DEPTH = 4;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
  } rgb_t;

  typedef struct packed {
    rgb_t img;
    rgb_t seg;
  } row_entry_t;

  typedef struct packed {
    rgb_t                 pix;
    logic [OUT_COL_W-1:0] column;
    logic [OUT_ROW_W-1:0] row;
    logic                 frame_end;
  } result_t;

endpackage

FILE: src/sbo_if.sv
interface sbo_in_if import sbo_pkg::*;;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] img_red;
  logic [PIX_W-1:0] img_green;
  logic [PIX_W-1:0] img_blue;
  logic [PIX_W-1:0] seg_red;
  logic [PIX_W-1:0] seg_green;
  logic [PIX_W-1:0] seg_blue;

  modport source (output valid, img_red, img_green, img_blue,
                  seg_red, seg_green, seg_blue, input ready);
  modport sink (input valid, img_red, img_green, img_blue,
                seg_red, seg_green, seg_blue, output ready);
endinterface

interface sbo_out_if import sbo_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [PIX_W-1:0]     out_red;
  logic [PIX_W-1:0]     out_green;
  logic [PIX_W-1:0]     out_blue;
  logic [OUT_COL_W-1:0] out_column;
  logic [OUT_ROW_W-1:0] out_row;
  logic                 frame_end;

  modport source (output valid, out_red, out_green, out_blue, out_column,
                  out_row, frame_end, input ready);
  modport sink (input valid, out_red, out_green, out_blue, out_column,
                out_row, frame_end, output ready);
endinterface

interface sbo_cfg_if import sbo_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: src/sbo_line_store.sv
module sbo_line_store import sbo_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  logic                         clk,
  input  logic                         re,
  input  logic                         we,
  input  logic [$clog2(MAX_WIDTH)-1:0] waddr,
  input  row_entry_t                   wdata,
  input  logic [$clog2(MAX_WIDTH)-1:0] raddr_a,
  input  logic [$clog2(MAX_WIDTH)-1:0] raddr_b,
  output row_entry_t                   rdata_a,
  output row_entry_t                   rdata_b
);

  row_entry_t mem [MAX_WIDTH];

  // read-first: a read at the written address returns the old entry
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

endmodule

FILE: src/segment_boundary_overlay.sv
// Pipeline: an accepted pixel is held in the stage 1 register, its results are
//   written from there into the output queue, which feeds the output port.
// Throughput: one pixel per cycle while the output queue has room; on the last
//   row two results per pixel, so the single output port throttles the input there.
// Reset: counters, frame size (640 x 480) and output queue cleared at once;
//   the line store is not cleared and needs no clearing pass.
module segment_boundary_overlay import sbo_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic       clk,
  input  logic       rst_n,
  sbo_in_if.sink     in_px,
  sbo_out_if.source  out_px,
  sbo_cfg_if.sink    cfg_wr
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);
  localparam int EW    = $clog2(MAX_WIDTH + 1);
  localparam int EH    = $clog2(MAX_HEIGHT + 1);
  localparam int QP_W  = $clog2(QUEUE_DEPTH);
  localparam int QC_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int QS_W  = QC_W + 2;

  // clamp the programmed size into 1..MAX
  function automatic logic [EW-1:0] clamp_w(input logic [FW_W-1:0] v);
    logic [EW-1:0] r;
    if (v == '0) r = EW'(1);
    else if (32'(v) > MAX_WIDTH) r = EW'(MAX_WIDTH);
    else r = EW'(v);
    return r;
  endfunction

  function automatic logic [EH-1:0] clamp_h(input logic [FH_W-1:0] v);
    logic [EH-1:0] r;
    if (v == '0) r = EH'(1);
    else if (32'(v) > MAX_HEIGHT) r = EH'(MAX_HEIGHT);
    else r = EH'(v);
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // configuration: stored already clamped; any known write restarts frame
  // ---------------------------------------------------------------------
  logic [EW-1:0] eff_w_r;
  logic [EH-1:0] eff_h_r;
  logic          cfg_fire;
  logic          cfg_restart;

  assign cfg_wr.ready = 1'b1;
  assign cfg_fire     = cfg_wr.valid;

  always_comb begin
    cfg_restart = 1'b0;
    if (cfg_fire) begin
      case (cfg_wr.index)
        REG_FRAME_WIDTH:  cfg_restart = 1'b1;
        REG_FRAME_HEIGHT: cfg_restart = 1'b1;
        default:          cfg_restart = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eff_w_r <= clamp_w(FW_W'(RESET_WIDTH));
      eff_h_r <= clamp_h(FH_W'(RESET_HEIGHT));
    end else if (cfg_fire) begin
      case (cfg_wr.index)
        REG_FRAME_WIDTH:  eff_w_r <= clamp_w(cfg_wr.data[FW_W-1:0]);
        REG_FRAME_HEIGHT: eff_h_r <= clamp_h(cfg_wr.data[FH_W-1:0]);
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // stage 1: raster position, line store read of entries x and x+1,
  // write of the current pixel into entry x (read-first)
  // ---------------------------------------------------------------------
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic             in_ready;
  logic             in_fire;
  logic             last_col;
  logic             last_row;
  rgb_t             cur_img;
  rgb_t             cur_seg;
  row_entry_t       wr_ent;

  assign cur_img = '{red: in_px.img_red, green: in_px.img_green, blue: in_px.img_blue};
  assign cur_seg = '{red: in_px.seg_red, green: in_px.seg_green, blue: in_px.seg_blue};
  assign wr_ent  = '{img: cur_img, seg: cur_seg};

  assign in_fire  = in_px.valid && in_ready;
  assign last_col = (EW'(col_r) + EW'(1)) == eff_w_r;
  assign last_row = (EH'(row_r) + EH'(1)) == eff_h_r;

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (in_fire) begin
      if (last_col) begin
        col_nxt = '0;
        row_nxt = last_row ? '0 : row_r + ROW_W'(1);
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_restart) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  row_entry_t old_ent;
  row_entry_t right_ent;

  sbo_line_store #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_line_store (
    .clk     (clk),
    .re      (in_fire),
    .we      (in_fire),
    .waddr   (col_r),
    .wdata   (wr_ent),
    .raddr_a (col_r),
    .raddr_b (col_r + COL_W'(1)),
    .rdata_a (old_ent),
    .rdata_b (right_ent)
  );

  // stage 1 register, aligned with the line store read data
  logic             s1_valid_r;
  logic [1:0]       s1_n_r;
  logic             s1_above_r;  // emits the pixel of the row above
  logic             s1_last_col_r;
  logic             s1_w_gt1_r;
  logic             s1_h_gt1_r;
  rgb_t             s1_img_r;
  rgb_t             s1_seg_r;
  logic [COL_W-1:0] s1_col_r;
  logic [ROW_W-1:0] s1_row_r;
  logic             emit_above;
  logic             emit_cur;

  assign emit_above = row_r != '0;
  assign emit_cur   = last_row;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s1_n_r     <= '0;
    end else begin
      s1_valid_r <= in_fire;
      s1_n_r     <= in_fire ? 2'({1'b0, emit_above} + {1'b0, emit_cur}) : 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_above_r    <= emit_above;
      s1_last_col_r <= last_col;
      s1_w_gt1_r    <= eff_w_r != EW'(1);
      s1_h_gt1_r    <= eff_h_r != EH'(1);
      s1_img_r      <= cur_img;
      s1_seg_r      <= cur_seg;
      s1_col_r      <= col_r;
      s1_row_r      <= row_r;
    end
  end

  // ---------------------------------------------------------------------
  // stage 2: boundary decision, push results into the output queue
  // ---------------------------------------------------------------------
  rgb_t ul_seg_r;  // label above, one column to the left

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_restart) begin
      ul_seg_r <= '0;
    end else if (s1_valid_r) begin
      ul_seg_r <= old_ent.seg;
    end
  end

  logic                         black_above;
  logic                         black_cur;
  logic [COL_W+OUT_COL_W-1:0]   col_ext;
  logic [ROW_W+OUT_ROW_W-1:0]   row_ext;
  logic [ROW_W+OUT_ROW_W-1:0]   row_up_ext;
  result_t                      res_above;
  result_t                      res_cur;
  result_t                      res_first;

  always_comb begin
    // last column looks left instead of right/down
    if (s1_last_col_r) begin
      black_above = s1_w_gt1_r && (old_ent.seg != ul_seg_r);
    end else begin
      black_above = (old_ent.seg != right_ent.seg) || (old_ent.seg != s1_seg_r);
    end
    black_cur = !s1_last_col_r && s1_h_gt1_r && (s1_seg_r != old_ent.seg);

    col_ext    = {{OUT_COL_W{1'b0}}, s1_col_r};
    row_ext    = {{OUT_ROW_W{1'b0}}, s1_row_r};
    row_up_ext = {{OUT_ROW_W{1'b0}}, s1_row_r - ROW_W'(1)};

    res_above.pix       = black_above ? '0 : old_ent.img;
    res_above.column    = col_ext[OUT_COL_W-1:0];
    res_above.row       = row_up_ext[OUT_ROW_W-1:0];
    res_above.frame_end = 1'b0;

    res_cur.pix       = black_cur ? '0 : s1_img_r;
    res_cur.column    = col_ext[OUT_COL_W-1:0];
    res_cur.row       = row_ext[OUT_ROW_W-1:0];
    res_cur.frame_end = s1_last_col_r;

    res_first = s1_above_r ? res_above : res_cur;
  end

  // output queue
  result_t         q_r [QUEUE_DEPTH];
  logic [QP_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QC_W-1:0] cnt_r, cnt_nxt;
  logic [1:0]      push_n;
  logic            pop;

  assign push_n = s1_valid_r ? s1_n_r : 2'd0;
  assign pop    = out_px.valid && out_px.ready;

  // accept only with room for this pixel and the one in stage 1
  assign in_ready = (QS_W'(cnt_r) + QS_W'(s1_n_r) + QS_W'(2)) <= QS_W'(QUEUE_DEPTH);
  assign in_px.ready = in_ready;

  assign cnt_nxt = cnt_r + QC_W'(push_n) - QC_W'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + QP_W'(push_n);
      rd_ptr_r <= rd_ptr_r + QP_W'(pop);
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      q_r[wr_ptr_r] <= res_first;
    end
    if (push_n == 2'd2) begin
      q_r[wr_ptr_r + QP_W'(1)] <= res_cur;
    end
  end

  result_t head;
  assign head = q_r[rd_ptr_r];

  assign out_px.valid      = cnt_r != '0;
  assign out_px.out_red    = head.pix.red;
  assign out_px.out_green  = head.pix.green;
  assign out_px.out_blue   = head.pix.blue;
  assign out_px.out_column = head.column;
  assign out_px.out_row    = head.row;
  assign out_px.frame_end  = head.frame_end;

endmodule

FILE: sim/segment_boundary_overlay_tb.sv
`timescale 1ns / 100ps

module segment_boundary_overlay_tb import sbo_pkg::*;;

  // ---------------------------------------------------------------------------
  // Run control
  // ---------------------------------------------------------------------------
  localparam int CYCLE_LIMIT   = 3_000_000; // watchdog, far beyond a slow run
  localparam int RANDOM_ITEMS  = 320;       // small random frames
  localparam int EXTREME_ITEMS = 24;        // per oversized or full-size frame
  localparam int SETTLE_CYCLES = 4;         // settle wait before register writes and at the end
  localparam int HOLD_CYCLES   = 64;        // long output hold-off
  localparam int REPORT_MAX    = 10;

  // unused register slot, a write there must change nothing
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = CFG_IDX_W'(15);

  // how a directed row gets its expectation
  localparam int USE_PREDICTOR = -1;
  localparam int NO_RESULT     = 0;
  localparam int ONE_RESULT    = 1;

  typedef enum logic {STEP_CFG, STEP_PIXEL} step_kind_e;

  typedef struct packed {
    step_kind_e            kind;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_value;
    rgb_t                  img;
    rgb_t                  seg;
    int                    fixed_n;
    result_t               want;
  } drill_t;

  // ---------------------------------------------------------------------------
  // Directed table. Typed expectations only where they are obvious: the first
  // pixel after reset, single-row and single-column frames, and the masked
  // width with a zero height. Everything else goes through the predictor.
  // ---------------------------------------------------------------------------
  localparam int N_DRILLS = 35;
  drill_t drills [N_DRILLS] = '{
    // reset frame is 640 x 480: row 0 emits nothing
    '{STEP_PIXEL, '0, '0, 24'h123456, 24'h000000, NO_RESULT, '0},
    // single row of three: every pixel copied at once, end flag on column 2
    '{STEP_CFG, REG_FRAME_WIDTH, 13'd3, '0, '0, NO_RESULT, '0},
    '{STEP_CFG, REG_FRAME_HEIGHT, 13'd1, '0, '0, NO_RESULT, '0},
    '{STEP_PIXEL, '0, '0, 24'hFFFFFF, 24'hFFFFFF, ONE_RESULT,
      '{24'hFFFFFF, 11'd0, 12'd0, 1'b0}},
    '{STEP_PIXEL, '0, '0, 24'h000000, 24'h000000, ONE_RESULT,
      '{24'h000000, 11'd1, 12'd0, 1'b0}},
    '{STEP_PIXEL, '0, '0, 24'hA55AC3, 24'h123456, ONE_RESULT,
      '{24'hA55AC3, 11'd2, 12'd0, 1'b1}},
    // counters wrapped after the frame end
    '{STEP_PIXEL, '0, '0, 24'h0FF081, 24'hFEDCBA, ONE_RESULT,
      '{24'h0FF081, 11'd0, 12'd0, 1'b0}},
    // single column of three: copied even though labels differ
    '{STEP_CFG, REG_FRAME_WIDTH, 13'd1, '0, '0, NO_RESULT, '0},
    '{STEP_CFG, REG_FRAME_HEIGHT, 13'd3, '0, '0, NO_RESULT, '0},
    '{STEP_PIXEL, '0, '0, 24'h112233, 24'hAAAAAA, NO_RESULT, '0},
    '{STEP_PIXEL, '0, '0, 24'h445566, 24'h555555, ONE_RESULT,
      '{24'h112233, 11'd0, 12'd0, 1'b0}},
    '{STEP_PIXEL, '0, '0, 24'h778899, 24'hFFFFFF, USE_PREDICTOR, '0},
    // zero width behaves as one
    '{STEP_CFG, REG_FRAME_WIDTH, 13'd0, '0, '0, NO_RESULT, '0},
    '{STEP_CFG, REG_FRAME_HEIGHT, 13'd2, '0, '0, NO_RESULT, '0},
    '{STEP_PIXEL, '0, '0, 24'h800000, 24'h000000, NO_RESULT, '0},
    '{STEP_PIXEL, '0, '0, 24'h008000, 24'hFFFFFF, USE_PREDICTOR, '0},
    // 2 x 2 with vertical stripes of labels
    '{STEP_CFG, REG_FRAME_WIDTH, 13'd2, '0, '0, NO_RESULT, '0},
    '{STEP_CFG, REG_FRAME_HEIGHT, 13'd2, '0, '0, NO_RESULT, '0},
    '{STEP_PIXEL, '0, '0, 24'h010203, 24'h000000, USE_PREDICTOR, '0},
    '{STEP_PIXEL, '0, '0, 24'h040506, 24'hFFFFFF, USE_PREDICTOR, '0},
    '{STEP_PIXEL, '0, '0, 24'h070809, 24'h000000, USE_PREDICTOR, '0},
    '{STEP_PIXEL, '0, '0, 24'h0A0B0C, 24'hFFFFFF, USE_PREDICTOR, '0},
    // width write keeps 12 bits (acts as 2), zero height acts as one row
    '{STEP_CFG, REG_FRAME_WIDTH, 13'h1002, '0, '0, NO_RESULT, '0},
    '{STEP_CFG, REG_FRAME_HEIGHT, 13'd0, '0, '0, NO_RESULT, '0},
    '{STEP_PIXEL, '0, '0, 24'h7F7F7F, 24'h010101, ONE_RESULT,
      '{24'h7F7F7F, 11'd0, 12'd0, 1'b0}},
    '{STEP_PIXEL, '0, '0, 24'h808080, 24'h020202, ONE_RESULT,
      '{24'h808080, 11'd1, 12'd0, 1'b1}},
    // 3 x 3, with a write to an unused slot mid-frame: frame must go on
    '{STEP_CFG, REG_FRAME_WIDTH, 13'd3, '0, '0, NO_RESULT, '0},
    '{STEP_CFG, REG_FRAME_HEIGHT, 13'd3, '0, '0, NO_RESULT, '0},
    '{STEP_PIXEL, '0, '0, 24'h111111, 24'h000000, USE_PREDICTOR, '0},
    '{STEP_PIXEL, '0, '0, 24'h222222, 24'h000000, USE_PREDICTOR, '0},
    '{STEP_PIXEL, '0, '0, 24'h333333, 24'hFFFFFF, USE_PREDICTOR, '0},
    '{STEP_PIXEL, '0, '0, 24'h444444, 24'h000000, USE_PREDICTOR, '0},
    '{STEP_CFG, REG_UNMAPPED, 13'h1FFF, '0, '0, NO_RESULT, '0},
    '{STEP_PIXEL, '0, '0, 24'h555555, 24'h000000, USE_PREDICTOR, '0},
    '{STEP_PIXEL, '0, '0, 24'h666666, 24'hFFFFFF, USE_PREDICTOR, '0}
  };

  // ---------------------------------------------------------------------------
  // Clock, reset, channels, block
  // ---------------------------------------------------------------------------
  logic clk;
  logic rst_n;

  sbo_in_if  in_px ();
  sbo_out_if out_px ();
  sbo_cfg_if cfg_wr ();

  segment_boundary_overlay uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_px  (in_px.sink),
    .out_px (out_px.source),
    .cfg_wr (cfg_wr.sink)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Overlay predictor: own copy of line store, position and frame size
  // ---------------------------------------------------------------------------
  row_entry_t       line_mem [DEF_MAX_WIDTH];
  int               col_pos = 0;
  int               row_pos = 0;
  rgb_t             left_above_label = '0; // label above, one column back
  logic [FW_W-1:0]  width_reg  = FW_W'(RESET_WIDTH);
  logic [FH_W-1:0]  height_reg = FH_W'(RESET_HEIGHT);

  result_t step_out [$];       // what the last pixel produced
  result_t pending_pixels [$]; // expected output pixels, oldest first

  // scoreboard and run statistics
  int   mismatches      = 0;
  int   pixels_sent     = 0;
  int   results_checked = 0;
  int   cfg_writes      = 0;
  int   cycle_count     = 0;
  int   hold_cycles     = 0; // set by the stimulus, counted down by the receiver
  bit   quiet           = 1'b0;

  function automatic void predict_step(input rgb_t img, input rgb_t seg);
    int         w;
    int         h;
    int         x;
    int         y;
    row_entry_t above;
    logic       black;
    result_t    r;
    w = (width_reg == 0) ? 1 : ((width_reg > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : int'(width_reg));
    h = (height_reg == 0) ? 1 :
        ((height_reg > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : int'(height_reg));
    x = (col_pos >= w) ? 0 : col_pos;
    y = (row_pos >= h) ? 0 : row_pos;
    above = line_mem[x];
    step_out.delete();

    // pixel above leaves once the one below it is known
    if (y > 0) begin
      if (x + 1 < w)
        black = (above.seg != line_mem[x+1].seg) || (above.seg != seg);
      else
        black = (w > 1) && (above.seg != left_above_label);
      r.pix       = black ? rgb_t'('0) : above.img;
      r.column    = OUT_COL_W'(x);
      r.row       = OUT_ROW_W'(y - 1);
      r.frame_end = 1'b0;
      step_out.push_back(r);
    end

    // last row has no lower neighbour: goes out right away
    if (y == h - 1) begin
      black       = (x + 1 < w) && (h > 1) && (seg != above.seg);
      r.pix       = black ? rgb_t'('0) : img;
      r.column    = OUT_COL_W'(x);
      r.row       = OUT_ROW_W'(y);
      r.frame_end = (x + 1 == w);
      step_out.push_back(r);
    end

    left_above_label = above.seg;
    line_mem[x].img  = img;
    line_mem[x].seg  = seg;
    x++;
    if (x >= w) begin
      x = 0;
      y++;
      if (y >= h) y = 0;
    end
    col_pos = x;
    row_pos = y;
  endfunction

  function automatic rgb_t random_rgb();
    logic [31:0] r;
    r = $urandom;
    return r[23:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus tasks
  // ---------------------------------------------------------------------------

  // drop valid and wait until every expected pixel has come out
  task automatic drain();
    @(negedge clk);
    in_px.valid = 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
  endtask

  // register writes only on an idle block
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_wr.valid = 1'b1;
    cfg_wr.index = idx;
    cfg_wr.data  = value;
    do @(posedge clk); while (cfg_wr.ready !== 1'b1);
    if (idx == REG_FRAME_WIDTH || idx == REG_FRAME_HEIGHT) begin
      if (idx == REG_FRAME_WIDTH)
        width_reg = value[FW_W-1:0];
      else
        height_reg = value[FH_W-1:0];
      // any frame size write restarts the frame
      col_pos          = 0;
      row_pos          = 0;
      left_above_label = '0;
    end
    cfg_writes++;
    @(negedge clk);
    cfg_wr.valid = 1'b0;
  endtask

  // one pixel transaction, with an optional idle burst in front
  task automatic push_pixel(input rgb_t img, input rgb_t seg, input int fixed_n,
                            input result_t want);
    int gap;
    gap = 0;
    if (!quiet && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 8);
    if (gap != 0) begin
      @(negedge clk);
      in_px.valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_px.valid     = 1'b1;
    in_px.img_red   = img.red;
    in_px.img_green = img.green;
    in_px.img_blue  = img.blue;
    in_px.seg_red   = seg.red;
    in_px.seg_green = seg.green;
    in_px.seg_blue  = seg.blue;
    do @(posedge clk); while (in_px.ready !== 1'b1);
    predict_step(img, seg);
    pixels_sent++;
    if (fixed_n == USE_PREDICTOR) begin
      foreach (step_out[i]) pending_pixels.push_back(step_out[i]);
    end else if (fixed_n == ONE_RESULT) begin
      pending_pixels.push_back(want);
    end
  endtask

  // one frame setting, n pixels; labels mostly from a small palette so that
  // neighbours match often and both copied and black pixels show up
  task automatic run_phase(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h,
                           input int n, input int hold_at, input int pause_at);
    rgb_t palette [3];
    rgb_t img;
    rgb_t seg;
    write_reg(REG_FRAME_WIDTH, w);
    write_reg(REG_FRAME_HEIGHT, h);
    foreach (palette[i]) palette[i] = random_rgb();
    for (int k = 0; k < n; k++) begin
      img = random_rgb();
      seg = ($urandom_range(0, 9) == 0) ? random_rgb() : palette[$urandom_range(0, 2)];
      push_pixel(img, seg, USE_PREDICTOR, '0);
      if (k == hold_at) hold_cycles = HOLD_CYCLES; // output stalls, input keeps going
      if (k == pause_at) drain();                  // sender waits for the tail
    end
  endtask

  // ---------------------------------------------------------------------------
  // Output side: ready in random bursts, plus the long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin
    int burst;
    burst = 0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_px.ready = 1'b0;
        hold_cycles--;
      end else if (burst > 0) begin
        out_px.ready = 1'b0;
        burst--;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        out_px.ready = 1'b0;
        burst = $urandom_range(0, 7);
      end else begin
        out_px.ready = 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Checker: every output transaction against the oldest expectation
  // ---------------------------------------------------------------------------
  initial begin
    result_t got;
    result_t want;
    logic    bad;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_px.valid === 1'b1 && out_px.ready === 1'b1) begin
        got.pix.red   = out_px.out_red;
        got.pix.green = out_px.out_green;
        got.pix.blue  = out_px.out_blue;
        got.column    = out_px.out_column;
        got.row       = out_px.out_row;
        got.frame_end = out_px.frame_end;
        if (pending_pixels.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("unexpected pixel: %h/%h/%h col %0d row %0d end %0b",
                     got.pix.red, got.pix.green, got.pix.blue, got.column, got.row,
                     got.frame_end);
        end else begin
          want = pending_pixels.pop_front();
          results_checked++;
          bad = (got.pix.red !== want.pix.red) || (got.pix.green !== want.pix.green) ||
                (got.pix.blue !== want.pix.blue) || (got.column !== want.column) ||
                (got.row !== want.row) || (got.frame_end !== want.frame_end);
          if (bad) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
              $display({"pixel mismatch: want %h/%h/%h col %0d row %0d end %0b, ",
                        "got %h/%h/%h col %0d row %0d end %0b"},
                       want.pix.red, want.pix.green, want.pix.blue, want.column, want.row,
                       want.frame_end, got.pix.red, got.pix.green, got.pix.blue,
                       got.column, got.row, got.frame_end);
          end
        end
      end
    end
  end

  // watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb: failure");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int random_items;
    int w;
    int h;
    int n;

    // every block input known from time zero
    rst_n            = 1'b0;
    in_px.valid      = 1'b0;
    in_px.img_red    = '0;
    in_px.img_green  = '0;
    in_px.img_blue   = '0;
    in_px.seg_red    = '0;
    in_px.seg_green  = '0;
    in_px.seg_blue   = '0;
    out_px.ready     = 1'b0;
    cfg_wr.valid     = 1'b0;
    cfg_wr.index     = '0;
    cfg_wr.data      = '0;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed table
    foreach (drills[i]) begin
      if (drills[i].kind == STEP_CFG)
        write_reg(drills[i].reg_idx, drills[i].reg_value);
      else
        push_pixel(drills[i].img, drills[i].seg, drills[i].fixed_n, drills[i].want);
    end

    // 3 x 8 frame: long output hold-off in row 2, then a full drain mid-frame
    run_phase(CFG_DATA_W'(3), CFG_DATA_W'(8), 30, 6, 15);
    random_items = 30;

    // small random frames, often ending mid-frame so restarts get exercised
    while (random_items < RANDOM_ITEMS) begin
      w = $urandom_range(1, 6);
      h = $urandom_range(1, 5);
      n = w * h * $urandom_range(1, 3) + $urandom_range(0, w);
      run_phase(CFG_DATA_W'(w), CFG_DATA_W'(h), n, -1, -1);
      random_items += n;
    end

    // extremes: full width, width beyond the limit, full and oversized height
    run_phase(CFG_DATA_W'(DEF_MAX_WIDTH), CFG_DATA_W'(1), EXTREME_ITEMS, -1, -1);
    run_phase(CFG_DATA_W'(4095), CFG_DATA_W'(1), EXTREME_ITEMS, -1, -1);
    run_phase(CFG_DATA_W'(1), CFG_DATA_W'(DEF_MAX_HEIGHT), EXTREME_ITEMS, -1, -1);
    run_phase(CFG_DATA_W'(1), CFG_DATA_W'(8191), EXTREME_ITEMS, -1, -1);

    // closing stretch at full rate, no idling on either side
    quiet = 1'b1;
    run_phase(CFG_DATA_W'(5), CFG_DATA_W'(4), 60, -1, -1);

    drain();
    repeat (SETTLE_CYCLES * 2) @(posedge clk);

    $display("run: %0d pixels over %0d register writes, %0d output pixels checked",
             pixels_sent, cfg_writes, results_checked);
    $display("run: frames from 1x1 to small random sizes, plus sizes at and past %0d x %0d",
             DEF_MAX_WIDTH, DEF_MAX_HEIGHT);
    if (mismatches == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
